// ===== rtl/stats_record_validator_core_macros.svh =====
// Assertion macros for the statistics record validator checker.
// Depends on nothing; included by srv_checker.sv.
`ifndef STATS_RECORD_VALIDATOR_CORE_MACROS_SVH
`define STATS_RECORD_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define SRV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srv_pkg.sv =====
// Shared types, constants and helpers for the statistics record validator.
// No dependencies.
package srv_pkg;

   localparam int LenSat      = 93;
   localparam int HeaderBytes = 16;
   localparam int PayloadV1   = 24;
   localparam int PayloadV2   = 72;
   localparam int ChecksumLen = 4;
   localparam int LenV1       = HeaderBytes + PayloadV1 + ChecksumLen;
   localparam int LenV2       = HeaderBytes + PayloadV2 + ChecksumLen;
   localparam int CounterEnd  = HeaderBytes + PayloadV2;
   localparam int NumCounters = 9;
   localparam int BaseCounters = 3;
   localparam int PosWidth    = 7;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_BAD_SIZE     = 3'd1,
      STATUS_BAD_MAGIC    = 3'd2,
      STATUS_BAD_VERSION  = 3'd3,
      STATUS_BAD_PAYLOAD  = 3'd4,
      STATUS_BAD_CHECKSUM = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      status_type                       status;
      logic [1:0]                       record_version;
      logic [NumCounters-1:0][63:0]     counters;
   } result_type;

   // Magic "DST1", one byte per header position.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h44;
         2'd1:    val = 8'h53;
         2'd2:    val = 8'h54;
         default: val = 8'h31;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/srv_channels.sv =====
// Valid/ready channel interfaces for record bytes and validation results.
// No dependencies.
interface srv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface srv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  record_version;
   logic [63:0] hit_count;
   logic [63:0] forward_count;
   logic [63:0] hit_time_sum;
   logic [63:0] wait_time_sum;
   logic [63:0] walked_node_sum;
   logic [63:0] store_count;
   logic [63:0] evict_scan_count;
   logic [63:0] evict_scan_time_sum;
   logic [63:0] evict_scan_node_sum;

   modport source (output valid, output status, output record_version,
                   output hit_count, output forward_count, output hit_time_sum,
                   output wait_time_sum, output walked_node_sum, output store_count,
                   output evict_scan_count, output evict_scan_time_sum,
                   output evict_scan_node_sum, input ready);
   modport sink   (input valid, input status, input record_version,
                   input hit_count, input forward_count, input hit_time_sum,
                   input wait_time_sum, input walked_node_sum, input store_count,
                   input evict_scan_count, input evict_scan_time_sum,
                   input evict_scan_node_sum, output ready);
endinterface

// ===== rtl/srv_input_stage.sv =====
// Input register for record bytes.
// Depends on srv_pkg and srv_req_if.
module srv_input_stage (
   input  logic              clock,
   input  logic              reset,
   srv_req_if.sink           req_if,
   input  logic              advance,
   output srv_pkg::item_type item,
   output logic              item_valid
);

   srv_pkg::item_type item_ff;
   logic              valid_ff;
   logic              take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{byte_value: req_if.byte_value, last_byte: req_if.last_byte};
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

// ===== rtl/srv_record_check.sv =====
// Record state, per-byte absorb, final checks and result register.
// Depends on srv_pkg and srv_rsp_if.
module srv_record_check (
   input  logic              clock,
   input  logic              reset,
   input  srv_pkg::item_type item,
   input  logic              item_valid,
   output logic              advance,
   srv_rsp_if.source         rsp_if
);

   localparam int PW = srv_pkg::PosWidth;
   localparam int NC = srv_pkg::NumCounters;

   logic [PW-1:0]         pos_ff, pos_in;
   logic [31:0]           sum_ff, sum_in;
   logic [31:0]           tail_ff, tail_in;
   logic                  magic_ff, magic_in;
   logic [31:0]           version_ff, version_in;
   logic [31:0]           payload_ff, payload_in;
   logic [NC-1:0][63:0]   counter_ff, counter_in;
   logic [PW-1:0]         k;
   logic [31:0]           want_payload;
   logic [PW-1:0]         want_len;
   logic [31:0]           tail_sum;
   srv_pkg::status_type   status;
   logic                  ok;
   srv_pkg::result_type   result_ff, result_in;
   logic                  out_valid_ff;

   assign advance = item_valid && (!item.last_byte || !out_valid_ff || rsp_if.ready);

   always_comb begin
      pos_in     = pos_ff;
      magic_in   = magic_ff;
      version_in = version_ff;
      payload_in = payload_ff;
      counter_in = counter_ff;
      k          = pos_ff - PW'(srv_pkg::HeaderBytes);
      if (pos_ff < PW'(srv_pkg::LenSat)) begin
         if (pos_ff < PW'(4)) begin
            if (item.byte_value != srv_pkg::magic_byte(pos_ff[1:0])) begin
               magic_in = 1'b0;
            end
         end else if (pos_ff < PW'(8)) begin
            version_in[{pos_ff[1:0], 3'b000} +: 8] = item.byte_value;
         end else if (pos_ff < PW'(12)) begin
            payload_in[{pos_ff[1:0], 3'b000} +: 8] = item.byte_value;
         end else if (pos_ff >= PW'(srv_pkg::HeaderBytes) &&
                      pos_ff < PW'(srv_pkg::CounterEnd)) begin
            for (int i = 0; i < NC; i++) begin
               if (k[PW-1:3] == (PW-3)'(i)) begin
                  counter_in[i][{k[2:0], 3'b000} +: 8] = item.byte_value;
               end
            end
         end
         pos_in = pos_ff + PW'(1);
      end
      sum_in  = sum_ff + 32'(item.byte_value);
      tail_in = {item.byte_value, tail_ff[31:8]};
   end

   always_comb begin
      want_payload = (version_in == 32'd1) ? 32'(srv_pkg::PayloadV1) : 32'(srv_pkg::PayloadV2);
      want_len     = (version_in == 32'd1) ? PW'(srv_pkg::LenV1) : PW'(srv_pkg::LenV2);
      tail_sum     = 32'(tail_in[7:0]) + 32'(tail_in[15:8])
                   + 32'(tail_in[23:16]) + 32'(tail_in[31:24]);
      if (pos_in != PW'(srv_pkg::LenV1) && pos_in != PW'(srv_pkg::LenV2)) begin
         status = srv_pkg::STATUS_BAD_SIZE;
      end else if (!magic_in) begin
         status = srv_pkg::STATUS_BAD_MAGIC;
      end else if (version_in == 32'd0 || version_in > 32'd2) begin
         status = srv_pkg::STATUS_BAD_VERSION;
      end else if (payload_in != want_payload || pos_in != want_len) begin
         status = srv_pkg::STATUS_BAD_PAYLOAD;
      end else if (tail_in != sum_in - tail_sum) begin
         status = srv_pkg::STATUS_BAD_CHECKSUM;
      end else begin
         status = srv_pkg::STATUS_OK;
      end
      ok = (status == srv_pkg::STATUS_OK);

      result_in.status         = status;
      result_in.record_version = ok ? version_in[1:0] : 2'd0;
      // Final byte never lands in a counter that an accepted record reports.
      for (int i = 0; i < NC; i++) begin
         result_in.counters[i] =
            (ok && (i < srv_pkg::BaseCounters || version_in == 32'd2)) ? counter_ff[i] : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_byte)) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         tail_ff    <= '0;
         magic_ff   <= 1'b1;
         version_ff <= '0;
         payload_ff <= '0;
         counter_ff <= '0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         tail_ff    <= tail_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         payload_ff <= payload_in;
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && item.last_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item.last_byte) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid               = out_valid_ff;
   assign rsp_if.status              = result_ff.status;
   assign rsp_if.record_version      = result_ff.record_version;
   assign rsp_if.hit_count           = result_ff.counters[0];
   assign rsp_if.forward_count       = result_ff.counters[1];
   assign rsp_if.hit_time_sum        = result_ff.counters[2];
   assign rsp_if.wait_time_sum       = result_ff.counters[3];
   assign rsp_if.walked_node_sum     = result_ff.counters[4];
   assign rsp_if.store_count         = result_ff.counters[5];
   assign rsp_if.evict_scan_count    = result_ff.counters[6];
   assign rsp_if.evict_scan_time_sum = result_ff.counters[7];
   assign rsp_if.evict_scan_node_sum = result_ff.counters[8];

endmodule

// ===== rtl/stats_record_validator_core.sv =====
// Channel    Dir  Transfer
// req_if     in   one record byte, last_byte flags the final one
// rsp_if     out  status, version and nine counters, once per record
//
// One byte per cycle sustained while no held result stalls a final byte; input register then absorb/check logic.
// A final byte passes the input register, then its result is registered in the result register.
// Synchronous reset clears record state and both valid flags.
// A held result stalls only a final byte; bytes before it keep flowing, bytes behind it wait.
// Depends on srv_pkg, srv_channels, srv_input_stage, srv_record_check.
module stats_record_validator_core (
   input logic       clock,
   input logic       reset,
   srv_req_if.sink   req_if,
   srv_rsp_if.source rsp_if
);

   srv_pkg::item_type item;
   logic              item_valid;
   logic              advance;

   srv_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item       (item),
      .item_valid (item_valid)
   );

   srv_record_check u_check (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .advance    (advance),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== rtl/srv_checker.sv =====
// Port-level checks on validation results, bound to the top level.
// Depends on srv_pkg and stats_record_validator_core_macros.svh.
`include "stats_record_validator_core_macros.svh"

module srv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [1:0]  rsp_version,
   input logic [63:0] rsp_hit_count,
   input logic [63:0] rsp_wait_time_sum,
   input logic [63:0] rsp_evict_node_sum
);

   `SRV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `SRV_ASSERT_IMPL(a_reject_zero, clock, reset, rsp_valid && rsp_status != srv_pkg::STATUS_OK, rsp_version == 2'd0 && rsp_hit_count == 64'd0, "rejected record shows data")
   `SRV_ASSERT_IMPL(a_ok_version, clock, reset, rsp_valid && rsp_status == srv_pkg::STATUS_OK, rsp_version == 2'd1 || rsp_version == 2'd2, "accepted record without version")
   `SRV_ASSERT_IMPL(a_v1_upper_zero, clock, reset, rsp_valid && rsp_version != 2'd2, rsp_wait_time_sum == 64'd0 && rsp_evict_node_sum == 64'd0, "upper counters set outside version 2")

endmodule

bind stats_record_validator_core srv_checker u_srv_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_version        (rsp_if.record_version),
   .rsp_hit_count      (rsp_if.hit_count),
   .rsp_wait_time_sum  (rsp_if.wait_time_sum),
   .rsp_evict_node_sum (rsp_if.evict_scan_node_sum)
);
